[sv/hdc_pkg.sv]
// package for the hyperboloid distance core: widths, latencies, constants, shared types
// no dependencies
`default_nettype none

package hdc_pkg;

    // default number of coordinates per point
    localparam int HDC_DIM     = 2;
    localparam int COORD_W     = 32;
    localparam int DIST_W      = 32;
    localparam int PROD_W      = 64;
    // room for the squared norm plus one, summed over up to six lanes
    localparam int SUM_W       = 67;

    // ln2 in Q0.64, rounded to nearest
    localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;

    // pipeline depths of the shared units
    localparam int SQRT_LAT    = 65;
    localparam int MUL_LAT     = 2;
    localparam int NORM_STAGES = 7;
    localparam int FRAC_BITS   = 32;
    localparam int LOG_LAT     = NORM_STAGES + FRAC_BITS * (MUL_LAT + 1);

    typedef logic [127:0] hdc_wide_t;

    // products found by one lane for one coordinate
    typedef struct packed {
        logic [PROD_W-1:0]        sq_a;
        logic [PROD_W-1:0]        sq_b;
        logic signed [PROD_W-1:0] dot;
    } hdc_lane_prod_t;

endpackage

`default_nettype wire

[sv/hyperboloid_distance_core.sv]
// top level of the hyperboloid distance core
// depends on hdc_pkg, hdc_lane, hdc_delay, hdc_mul64, hdc_isqrt, hdc_log2
`default_nettype none

// Computes the hyperbolic (Lorentz model) distance between two points of DIM
// signed Q16.16 coordinates and returns it as unsigned Q8.24. The pipeline takes
// one point pair per clock unless the output stalls; it is fully pipelined:
// two chained 65-stage square-root pipelines (lifting to the hyperboloid and the
// acosh root term), a 103-stage log2 unit (7 normalize stages plus 32 squaring
// steps of 3 stages each), three 2-stage multipliers and five glue stages. The
// pipeline advances as a whole; when a result word waits on m_tready every stage
// holds and s_tready drops in the same cycle. The block has no state across words.

module hyperboloid_distance_core import hdc_pkg::*; #(
    parameter int DIM = HDC_DIM
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    // a_coord_0 .. a_coord_{DIM-1}, b_coord_0 .. b_coord_{DIM-1}, 32 bits each
    input  wire logic [2*DIM*COORD_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    // distance
    output logic [DIST_W-1:0]               m_tdata
);

    localparam int LAT = 1 + 1 + SQRT_LAT + MUL_LAT + 1 + SQRT_LAT + MUL_LAT + 1
                       + LOG_LAT + MUL_LAT + 1;
    localparam int D_DLY = SQRT_LAT + MUL_LAT;
    localparam int Z_DLY = SQRT_LAT + MUL_LAT + 1 + LOG_LAT + MUL_LAT;
    localparam int LVW   = 6 + FRAC_BITS;

    logic                     en;
    logic [LAT-1:0]           vld_reg;
    hdc_lane_prod_t           prod [DIM];
    logic [SUM_W-1:0]         sa_reg, sa_next, sb_reg, sb_next;
    logic signed [SUM_W-1:0]  d_reg, d_next, d_dly;
    logic [63:0]              ta, tb, se, sf;
    logic [127:0]             pab, ps, pf;
    logic signed [129:0]      alpha;
    hdc_wide_t                e_reg, e_dly, w_reg;
    logic                     zero_reg, zero_dly;
    logic [LVW-1:0]           lval;
    logic [127:0]             rounded;
    logic [DIST_W-1:0]        m_tdata_reg;

    // whole pipeline moves unless the output word is stalled
    assign en       = !vld_reg[LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_tdata  = m_tdata_reg;

    // valid bits follow the words through the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
        end
    end

    // coordinate lanes
    for (genvar i = 0; i < DIM; i++) begin : g_lane
        hdc_lane u_lane (
            .aclk    (aclk),
            .en      (en),
            .a_coord (s_tdata[i*COORD_W +: COORD_W]),
            .b_coord (s_tdata[(DIM+i)*COORD_W +: COORD_W]),
            .prod    (prod[i])
        );
    end

    // merge lanes: squared norms plus one, and the dot product
    always_comb begin
        sa_next = SUM_W'(1) << 32;
        sb_next = SUM_W'(1) << 32;
        d_next  = '0;
        for (int i = 0; i < DIM; i++) begin
            sa_next = sa_next + SUM_W'(prod[i].sq_a);
            sb_next = sb_next + SUM_W'(prod[i].sq_b);
            d_next  = d_next + SUM_W'(prod[i].dot);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sa_reg <= sa_next;
            sb_reg <= sb_next;
            d_reg  <= d_next;
        end
    end

    // time coordinates of both points
    hdc_isqrt u_sqrt_a (
        .aclk (aclk), .en (en), .n (128'(sa_reg) << 58), .root (ta)
    );
    hdc_isqrt u_sqrt_b (
        .aclk (aclk), .en (en), .n (128'(sb_reg) << 58), .root (tb)
    );

    hdc_delay #(.W(SUM_W), .N(D_DLY)) u_d_dly (
        .aclk (aclk), .en (en), .d (d_reg), .q (d_dly)
    );

    hdc_mul64 u_mul_t (
        .aclk (aclk), .en (en), .a (ta), .b (tb), .p (pab)
    );

    // alpha minus one, and the clamp flag
    assign alpha = $signed({2'b00, pab}) - ($signed(130'(d_dly)) <<< 58)
                 - (130'(1) << 90);

    always_ff @(posedge aclk) begin
        if (en) begin
            e_reg    <= alpha[127:0];
            zero_reg <= alpha[129] || (alpha == '0);
        end
    end

    // roots of e and e plus two
    hdc_isqrt u_sqrt_e (
        .aclk (aclk), .en (en), .n (e_reg), .root (se)
    );
    hdc_isqrt u_sqrt_f (
        .aclk (aclk), .en (en), .n (e_reg + (128'(1) << 91)), .root (sf)
    );

    hdc_delay #(.W(128), .N(D_DLY)) u_e_dly (
        .aclk (aclk), .en (en), .d (e_reg), .q (e_dly)
    );
    hdc_delay #(.W(1), .N(Z_DLY)) u_z_dly (
        .aclk (aclk), .en (en), .d (zero_reg), .q (zero_dly)
    );

    hdc_mul64 u_mul_s (
        .aclk (aclk), .en (en), .a (se), .b (sf), .p (ps)
    );

    // argument of the logarithm
    always_ff @(posedge aclk) begin
        if (en) begin
            w_reg <= e_dly + (128'(1) << 90) + ps;
        end
    end

    hdc_log2 u_log (
        .aclk (aclk), .en (en), .w (w_reg), .lval (lval)
    );

    // scale by ln2 and round half up to Q8.24
    hdc_mul64 u_mul_ln2 (
        .aclk (aclk), .en (en), .a (64'(lval)), .b (LN2_Q64), .p (pf)
    );

    assign rounded = pf + (128'(1) << 71);

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg <= zero_dly ? '0 : rounded[72 +: DIST_W];
        end
    end

endmodule

`default_nettype wire

[sv/hdc_lane.sv]
// one coordinate lane: squares of both coordinates and their cross product
// depends on hdc_pkg
`default_nettype none

module hdc_lane import hdc_pkg::*; (
    input  wire logic                      aclk,
    input  wire logic                      en,
    input  wire logic signed [COORD_W-1:0] a_coord,
    input  wire logic signed [COORD_W-1:0] b_coord,
    output hdc_lane_prod_t                 prod
);

    hdc_lane_prod_t   prod_reg, prod_next;
    logic signed [PROD_W-1:0] p_aa, p_bb, p_ab;

    // three 32 by 32 signed products
    always_comb begin
        p_aa = a_coord * a_coord;
        p_bb = b_coord * b_coord;
        p_ab = a_coord * b_coord;
        prod_next.sq_a = p_aa;
        prod_next.sq_b = p_bb;
        prod_next.dot  = p_ab;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[sv/hdc_delay.sv]
// fixed-length delay line that moves with the pipeline enable
// no dependencies
`default_nettype none

module hdc_delay #(
    parameter int W = 1,
    parameter int N = 1
) (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [W-1:0] d,
    output logic [W-1:0]      q
);

    logic [W-1:0] tap_reg [N];

    always_ff @(posedge aclk) begin
        if (en) begin
            tap_reg[0] <= d;
            for (int i = 1; i < N; i++) begin
                tap_reg[i] <= tap_reg[i-1];
            end
        end
    end

    assign q = tap_reg[N-1];

endmodule

`default_nettype wire

[sv/hdc_mul64.sv]
// 64 by 64 unsigned multiplier in two stages: partial products, then their sum
// no dependencies
`default_nettype none

module hdc_mul64 (
    input  wire logic         aclk,
    input  wire logic         en,
    input  wire logic [63:0]  a,
    input  wire logic [63:0]  b,
    output logic [127:0]      p
);

    logic [63:0]  p00_reg, p01_reg, p10_reg, p11_reg;
    logic [127:0] p_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            // four 32 by 32 partial products
            p00_reg <= a[31:0]  * b[31:0];
            p01_reg <= a[31:0]  * b[63:32];
            p10_reg <= a[63:32] * b[31:0];
            p11_reg <= a[63:32] * b[63:32];
            // aligned sum
            p_reg   <= {64'd0, p00_reg} + {32'd0, p01_reg, 32'd0}
                     + {32'd0, p10_reg, 32'd0} + {p11_reg, 64'd0};
        end
    end

    assign p = p_reg;

endmodule

`default_nettype wire

[sv/hdc_isqrt.sv]
// pipelined integer square root of a 128-bit word, one root bit per stage
// depends on hdc_pkg
`default_nettype none

module hdc_isqrt import hdc_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        en,
    input  wire hdc_wide_t   n,
    output logic [63:0]      root
);

    localparam int RW = 64;
    localparam int NW = 2 * RW;

    logic [NW-1:0] n_reg  [RW];
    logic [RW-1:0] r_reg  [RW+1];
    logic [NW-1:0] sq_reg [RW+1];

    // input register
    always_ff @(posedge aclk) begin
        if (en) begin
            n_reg[0]  <= n;
            r_reg[0]  <= '0;
            sq_reg[0] <= '0;
        end
    end

    // each stage tries one bit, keeping the square of the partial root
    for (genvar i = 0; i < RW; i++) begin : g_bit
        localparam int B = RW - 1 - i;
        logic [NW:0] trial;
        logic        take;

        assign trial = {1'b0, sq_reg[i]} + ((NW+1)'(r_reg[i]) << (B + 1))
                     + ((NW+1)'(1) << (2 * B));
        assign take  = {1'b0, n_reg[i]} >= trial;

        always_ff @(posedge aclk) begin
            if (en) begin
                r_reg[i+1]  <= take ? (r_reg[i] | (RW'(1) << B)) : r_reg[i];
                sq_reg[i+1] <= take ? trial[NW-1:0] : sq_reg[i];
            end
        end

        if (i < RW - 1) begin : g_pass
            always_ff @(posedge aclk) begin
                if (en) begin
                    n_reg[i+1] <= n_reg[i];
                end
            end
        end
    end

    assign root = r_reg[RW];

endmodule

`default_nettype wire

[sv/hdc_log2.sv]
// pipelined log2 of a 128-bit word with 90 fraction bits: normalize, then square per bit
// depends on hdc_pkg, hdc_mul64, hdc_delay
`default_nettype none

module hdc_log2 import hdc_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  en,
    input  wire hdc_wide_t             w,
    output logic [6+FRAC_BITS-1:0]     lval
);

    localparam int KW = 6;
    localparam int LW = KW + FRAC_BITS;

    hdc_wide_t      v_reg    [NORM_STAGES];
    logic [6:0]     lz_reg   [NORM_STAGES];
    logic [63:0]    m_reg    [FRAC_BITS-1];
    logic [FRAC_BITS-1:0] frac_reg [FRAC_BITS];
    logic [KW-1:0]  k_reg    [FRAC_BITS];
    logic [63:0]    m0;
    logic [KW-1:0]  k0;

    // leading zero count in binary steps of 64 down to 1
    for (genvar j = 0; j < NORM_STAGES; j++) begin : g_norm
        localparam int SH = 64 >> j;
        hdc_wide_t  v_cur;
        logic [6:0] lz_cur;
        logic       top_zero;

        if (j == 0) begin : g_first
            assign v_cur  = w;
            assign lz_cur = '0;
        end else begin : g_next
            assign v_cur  = v_reg[j-1];
            assign lz_cur = lz_reg[j-1];
        end

        assign top_zero = (v_cur[127 -: SH] == '0);

        always_ff @(posedge aclk) begin
            if (en) begin
                v_reg[j]  <= top_zero ? (v_cur << SH) : v_cur;
                lz_reg[j] <= lz_cur | (top_zero ? 7'(SH) : 7'd0);
            end
        end
    end

    // integer part from the msb position, mantissa in Q1.62
    assign k0 = KW'(7'd37 - lz_reg[NORM_STAGES-1]);
    assign m0 = {1'b0, v_reg[NORM_STAGES-1][127:65]};

    // one fraction bit per squaring step
    for (genvar i = 0; i < FRAC_BITS; i++) begin : g_bit
        logic [63:0]          m_cur;
        logic [FRAC_BITS-1:0] f_cur;
        logic [KW-1:0]        k_cur;
        logic [127:0]         p;
        logic [LW-1:0]        kf_d;
        logic [63:0]          sq;

        if (i == 0) begin : g_first
            assign m_cur = m0;
            assign f_cur = '0;
            assign k_cur = k0;
        end else begin : g_next
            assign m_cur = m_reg[i-1];
            assign f_cur = frac_reg[i-1];
            assign k_cur = k_reg[i-1];
        end

        hdc_mul64 u_sq (
            .aclk (aclk),
            .en   (en),
            .a    (m_cur),
            .b    (m_cur),
            .p    (p)
        );

        hdc_delay #(.W(LW), .N(MUL_LAT)) u_kf (
            .aclk (aclk),
            .en   (en),
            .d    ({k_cur, f_cur}),
            .q    (kf_d)
        );

        assign sq = p[125:62];

        always_ff @(posedge aclk) begin
            if (en) begin
                frac_reg[i] <= kf_d[FRAC_BITS-1:0]
                             | (sq[63] ? (FRAC_BITS'(1) << (FRAC_BITS - 1 - i))
                                       : FRAC_BITS'(0));
                k_reg[i]    <= kf_d[LW-1:FRAC_BITS];
            end
        end

        if (i < FRAC_BITS - 1) begin : g_mant
            always_ff @(posedge aclk) begin
                if (en) begin
                    m_reg[i] <= sq[63] ? (sq >> 1) : sq;
                end
            end
        end
    end

    assign lval = {k_reg[FRAC_BITS-1], frac_reg[FRAC_BITS-1]};

endmodule

`default_nettype wire

[sv/hdc_checker.sv]
// port-level checks for the hyperboloid distance core, bound to the top level
// depends on hdc_pkg and hyperboloid_distance_core
`default_nettype none

module hdc_checker import hdc_pkg::*; #(
    parameter int DIM = HDC_DIM
) (
    input wire logic                     aclk,
    input wire logic                     aresetn,
    input wire logic                     s_tvalid,
    input wire logic                     s_tready,
    input wire logic [2*DIM*COORD_W-1:0] s_tdata,
    input wire logic                     m_tvalid,
    input wire logic                     m_tready,
    input wire logic [DIST_W-1:0]        m_tdata
);

    // a stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // input side stalls exactly when the output word is stuck
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow the output stall");

    // reset empties the pipeline
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

    // the largest distance stays below 2^29 units
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:29] == 3'd0))
        else $error("distance out of range");

    // accepted input words carry known coordinates
    a_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |-> !$isunknown(s_tdata))
        else $error("unknown coordinates accepted");

endmodule

bind hyperboloid_distance_core hdc_checker #(.DIM(DIM)) u_hdc_checker (.*);

`default_nettype wire
